[src/first_fit_block_allocator_assert.svh]
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
// implication checked on every edge out of reset
`define FFBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/ffba_pkg.sv]
package ffba_pkg;
    localparam int ARENA_BYTES  = 1024;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_W  = 10;
    // running address needs headroom beyond 10 bits
    localparam int ADDR_W = 12;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_NULL    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [SZ_W:0] entry_t; // {free, bytes}
endpackage

[src/first_fit_block_allocator.sv]
// channel | dir | tdata fields (low bit up)                            | tuser
// s_      | in  | op[0], request_bytes[10:1], release_offset[20:11]    | -
// m_      | out | payload_offset[9:0], status[11:10]                   | -
// Each table entry that a request visits passes the single RAM read port.
// After reset the table is swept clear (entry 0 becomes one free block); s_tready is low.
// s_tready is low while a request runs and while a result waits on m_.
// Results hold stable under m_tready low.
`include "first_fit_block_allocator_assert.svh"
module first_fit_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // op, request_bytes, release_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // payload_offset, status
);
    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;
    localparam int SW = ffba_pkg::SZ_W;
    localparam int AW = ffba_pkg::ADDR_W;
    localparam logic [SW-1:0] HDR = SW'(ffba_pkg::HEADER_BYTES);
    localparam logic [CW-1:0] MAXB = CW'(ffba_pkg::MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT,
        S_MERGE_RD, S_MERGE, S_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg, i_reg;
    logic [AW-1:0] addr_reg;
    logic op_reg;
    logic [SW-1:0] req_reg, rel_reg;
    logic [SW-1:0] out_off_reg;
    logic [1:0] out_st_reg;
    // split: rest entry being carried through the insertion shift
    logic [SW:0] carry_reg;
    logic [SW:0] prev_reg; // merge: entry at write index
    logic [CW-1:0] w_reg;  // merge write index
    logic have_prev_reg;

    logic we;
    logic [IW-1:0] waddr, raddr;
    ffba_pkg::entry_t wdata, rdata;

    ffba_ram #(.WIDTH(SW + 1), .DEPTH(ffba_pkg::MAX_BLOCKS)) u_tab (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic rd_free;
    logic [SW-1:0] rd_bytes;
    assign rd_free  = rdata[SW];
    assign rd_bytes = rdata[SW-1:0];

    logic [SW+1:0] need;
    assign need = {2'b0, req_reg} + {2'b0, HDR};
    logic [AW-1:0] poff;
    assign poff = addr_reg + AW'(HDR);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'b0, out_st_reg, out_off_reg};

    // read address follows the scan index
    assign raddr = i_reg[IW-1:0];

    always_comb begin
        we = 1'b0;
        waddr = i_reg[IW-1:0];
        wdata = rdata;
        unique case (state_reg)
            S_CLR: begin
                we = 1'b1;
                wdata = (i_reg == '0) ? {1'b1, SW'(ffba_pkg::ARENA_BYTES - ffba_pkg::HEADER_BYTES)}
                                      : '0;
            end
            S_SCAN: begin
                if (!op_reg) begin
                    if (rd_free && rd_bytes >= req_reg) begin
                        we = 1'b1;
                        if ({2'b0, rd_bytes} > need && count_reg < MAXB)
                            wdata = {1'b0, req_reg};
                        else
                            wdata = {1'b0, rd_bytes};
                    end
                end else if (poff == AW'(rel_reg)) begin
                    we = 1'b1;
                    wdata = {1'b1, rd_bytes};
                end
            end
            S_SHIFT: begin
                we = 1'b1;
                wdata = carry_reg;
            end
            S_MERGE_RD: begin
                // last kept entry goes back on the way out
                if (i_reg >= count_reg && have_prev_reg) begin
                    we = 1'b1;
                    waddr = w_reg[IW-1:0];
                    wdata = prev_reg;
                end
            end
            S_MERGE: begin
                we = have_prev_reg;
                waddr = w_reg[IW-1:0];
                if (prev_reg[SW] && rd_free)
                    wdata = {1'b1, prev_reg[SW-1:0] + HDR + rd_bytes};
                else
                    wdata = prev_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            i_reg <= '0;
            count_reg <= CW'(1);
        end else begin
            unique case (state_reg)
                S_CLR: begin
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == MAXB - 1'b1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= s_tdata[0];
                        req_reg <= s_tdata[10:1];
                        rel_reg <= s_tdata[20:11];
                        i_reg <= '0;
                        addr_reg <= '0;
                        out_off_reg <= '0;
                        if (s_tdata[0] == ffba_pkg::OP_FREE && s_tdata[20:11] == '0) begin
                            out_st_reg <= ffba_pkg::ST_NULL;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (i_reg >= count_reg) begin
                        out_st_reg <= op_reg ? ffba_pkg::ST_UNKNOWN : ffba_pkg::ST_NOFIT;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!op_reg) begin
                        if (rd_free && rd_bytes >= req_reg) begin
                            out_st_reg <= ffba_pkg::ST_OK;
                            out_off_reg <= poff[SW-1:0];
                            if ({2'b0, rd_bytes} > need && count_reg < MAXB) begin
                                carry_reg <= {1'b1, rd_bytes - req_reg - HDR};
                                count_reg <= count_reg + 1'b1;
                                i_reg <= i_reg + 1'b1;
                                state_reg <= S_SHIFT_RD;
                            end else begin
                                state_reg <= S_OUT;
                            end
                        end else begin
                            addr_reg <= addr_reg + AW'(HDR) + AW'(rd_bytes);
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_SCAN_RD;
                        end
                    end else if (poff == AW'(rel_reg)) begin
                        out_st_reg <= ffba_pkg::ST_OK;
                        i_reg <= '0;
                        w_reg <= '0;
                        have_prev_reg <= 1'b0;
                        state_reg <= S_MERGE_RD;
                    end else begin
                        addr_reg <= addr_reg + AW'(HDR) + AW'(rd_bytes);
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SHIFT_RD: begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT: begin
                    // write carried entry here, pick up the old one
                    carry_reg <= rdata;
                    if (i_reg == count_reg - 1'b1) begin
                        state_reg <= S_OUT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_MERGE_RD: begin
                    if (i_reg >= count_reg) begin
                        // kept entries end at the write index
                        state_reg <= S_OUT;
                        count_reg <= w_reg + CW'(have_prev_reg);
                    end else begin
                        state_reg <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_MERGE_RD;
                    if (!have_prev_reg) begin
                        prev_reg <= rdata;
                        have_prev_reg <= 1'b1;
                    end else if (prev_reg[SW] && rd_free) begin
                        prev_reg <= {1'b1, prev_reg[SW-1:0] + HDR + rd_bytes};
                    end else begin
                        prev_reg <= rdata;
                        w_reg <= w_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `FFBA_ASSERT_IMP(a_busy_not_ready, m_tvalid, !s_tready)
    `FFBA_ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FFBA_ASSERT_IMP(a_count_range, state_reg == S_IDLE, count_reg >= CW'(1) && count_reg <= MAXB)
endmodule

[src/ffba_ram.sv]
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[tb/testbench.sv]
module testbench;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int QUIET_TAIL  = 150;
    localparam int SZ_W        = ffba_pkg::SZ_W;
    localparam int MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS;
    localparam int HDR_BYTES   = ffba_pkg::HEADER_BYTES;

    typedef struct {
        logic [SZ_W-1:0] bytes [MAX_BLOCKS];
        bit              is_free [MAX_BLOCKS];
        int              count;
    } heap_t;

    typedef struct {
        logic            op;
        logic [SZ_W-1:0] req;
        logic [SZ_W-1:0] rel;
        bit              hold;  // wait until nothing is outstanding
    } request_t;

    typedef struct {
        logic [SZ_W-1:0] offset;
        logic [1:0]      status;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    first_fit_block_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    request_t         pending_reqs[$];
    reply_t           expected_replies[$];
    heap_t            gen_heap;
    heap_t            dut_heap;
    logic [SZ_W-1:0]  live_offsets[$];
    int               n_sent = 0;
    int               n_got = 0;
    int               n_errors = 0;
    bit               quiet = 1'b0;
    int               cycles = 0;

    function automatic void heap_reset(inout heap_t h);
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            h.bytes[k] = '0;
            h.is_free[k] = 1'b0;
        end
        h.bytes[0] = SZ_W'(ffba_pkg::ARENA_BYTES - HDR_BYTES);
        h.is_free[0] = 1'b1;
        h.count = 1;
    endfunction

    function automatic reply_t heap_serve(inout heap_t h, input request_t r);
        reply_t res;
        int     addr;
        int     hit;
        int     rest;
        int     i;
        res.offset = '0;
        addr = 0;
        hit = -1;
        if (r.op == ffba_pkg::OP_ALLOC) begin
            res.status = ffba_pkg::ST_NOFIT;
            for (i = 0; i < h.count && hit < 0; i++) begin
                if (h.is_free[i] && int'(h.bytes[i]) >= int'(r.req)) hit = i;
                else addr += HDR_BYTES + int'(h.bytes[i]);
            end
            if (hit >= 0) begin
                if (int'(h.bytes[hit]) > int'(r.req) + HDR_BYTES && h.count < MAX_BLOCKS) begin
                    rest = int'(h.bytes[hit]) - int'(r.req) - HDR_BYTES;
                    for (int k = h.count; k > hit + 1; k--) begin
                        h.bytes[k] = h.bytes[k-1];
                        h.is_free[k] = h.is_free[k-1];
                    end
                    h.bytes[hit] = r.req;
                    h.bytes[hit+1] = SZ_W'(rest);
                    h.is_free[hit+1] = 1'b1;
                    h.count++;
                end
                h.is_free[hit] = 1'b0;
                res.offset = SZ_W'(addr + HDR_BYTES);
                res.status = ffba_pkg::ST_OK;
            end
        end else if (r.rel == '0) begin
            res.status = ffba_pkg::ST_NULL;
        end else begin
            res.status = ffba_pkg::ST_UNKNOWN;
            for (i = 0; i < h.count && hit < 0; i++) begin
                if (addr + HDR_BYTES == int'(r.rel)) hit = i;
                else addr += HDR_BYTES + int'(h.bytes[i]);
            end
            if (hit >= 0) begin
                h.is_free[hit] = 1'b1;
                res.status = ffba_pkg::ST_OK;
                // coalesce every run of neighbouring free blocks
                i = 0;
                while (i + 1 < h.count) begin
                    if (h.is_free[i] && h.is_free[i+1]) begin
                        h.bytes[i] = SZ_W'(int'(h.bytes[i]) + HDR_BYTES + int'(h.bytes[i+1]));
                        for (int k = i + 1; k + 1 < h.count; k++) begin
                            h.bytes[k] = h.bytes[k+1];
                            h.is_free[k] = h.is_free[k+1];
                        end
                        h.count--;
                        h.bytes[h.count] = '0;
                        h.is_free[h.count] = 1'b0;
                    end else begin
                        i++;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic queue_request(input logic op, input int req, input int rel, input bit hold);
        request_t r;
        reply_t   res;
        r.op = op;
        r.req = SZ_W'(req);
        r.rel = SZ_W'(rel);
        r.hold = hold;
        pending_reqs.push_back(r);
        res = heap_serve(gen_heap, r);
        if (op == ffba_pkg::OP_ALLOC && res.status == ffba_pkg::ST_OK)
            live_offsets.push_back(res.offset);
    endtask

    task automatic release_live(input int idx, input bit keep);
        queue_request(ffba_pkg::OP_FREE, 0, int'(live_offsets[idx]), 1'b0);
        if (!keep) live_offsets.delete(idx);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at beat %0d: %s got %0d expected %0d", n_got, what, got, want);
        n_errors++;
    endtask

    // driver
    int drv_gap = 0;
    always @(posedge aclk) begin
        request_t r;
        logic     nxt_valid;
        reply_t   res;
        nxt_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                r = pending_reqs.pop_front();
                res = heap_serve(dut_heap, r);
                expected_replies.push_back(res);
                n_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_reqs.size() > 0) begin
                    if (!quiet && $urandom_range(7) == 0) begin
                        drv_gap = $urandom_range(1, 9);
                    end else if (!pending_reqs[0].hold || n_sent == n_got) begin
                        s_tdata <= {3'b0, pending_reqs[0].rel, pending_reqs[0].req,
                                    pending_reqs[0].op};
                        nxt_valid = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // long receiver hold-off so the block backs up onto its input
    int long_hold = 0;
    bit long_done = 1'b0;
    always @(posedge aclk) begin
        if (long_hold > 0) begin
            long_hold--;
        end else if (aresetn && !long_done && n_got >= 300) begin
            long_hold = 600;
            long_done = 1'b1;
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge aclk) begin
        reply_t want;
        logic   nxt_ready;
        nxt_ready = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected beat, offset", int'(m_tdata[9:0]), -1);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tdata[9:0] !== want.offset)
                        report_mismatch("payload_offset", int'(m_tdata[9:0]), int'(want.offset));
                    if (m_tdata[11:10] !== want.status)
                        report_mismatch("status", int'(m_tdata[11:10]), int'(want.status));
                end
                n_got++;
            end
            if (long_hold > 0) begin
                nxt_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end else if (!quiet && $urandom_range(7) == 0) begin
                rx_gap = $urandom_range(1, 9);
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_tready <= nxt_ready;
    end

    always @(posedge aclk) begin
        cycles++;
        if (pending_reqs.size() < QUIET_TAIL) quiet <= 1'b1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int sz;
        heap_reset(gen_heap);
        heap_reset(dut_heap);

        // directed: edges of the fields and each corner of the allocator
        queue_request(ffba_pkg::OP_ALLOC, 0, 0, 1'b0);      // zero-byte request still splits
        queue_request(ffba_pkg::OP_ALLOC, 100, 0, 1'b0);
        queue_request(ffba_pkg::OP_ALLOC, 1023, 0, 1'b0);   // no fit
        queue_request(ffba_pkg::OP_FREE, 0, 0, 1'b0);       // null free
        queue_request(ffba_pkg::OP_FREE, 0, 1023, 1'b0);    // unknown offset
        queue_request(ffba_pkg::OP_FREE, 1023, 5, 1'b0);
        queue_request(ffba_pkg::OP_ALLOC, 682, 0, 1'b0);
        release_live(1, 1'b1);
        release_live(1, 1'b0);                              // double free
        queue_request(ffba_pkg::OP_ALLOC, 341, 0, 1'b0);
        while (live_offsets.size() > 0) release_live(0, 1'b0);
        // exact fit
        queue_request(ffba_pkg::OP_ALLOC, ffba_pkg::ARENA_BYTES - HDR_BYTES, 0, 1'b0);
        release_live(0, 1'b0);
        // no room to split
        queue_request(ffba_pkg::OP_ALLOC, ffba_pkg::ARENA_BYTES - 2*HDR_BYTES, 0, 1'b0);
        release_live(0, 1'b0);
        for (int k = 0; k < 6; k++) queue_request(ffba_pkg::OP_ALLOC, 0, 0, 1'b0);
        release_live(2, 1'b0);
        release_live(3, 1'b0);
        release_live(2, 1'b0);                              // merges across a run
        queue_request(ffba_pkg::OP_FREE, 0, 1, 1'b0);

        for (int n = 0; n < 1600; n++) begin
            r = $urandom_range(99);
            if (r < 50 || (r < 85 && live_offsets.size() == 0)) begin
                sz = ($urandom_range(9) < 8) ? $urandom_range(0, 120) : $urandom_range(0, 1023);
                queue_request(ffba_pkg::OP_ALLOC, sz, $urandom_range(0, 1023), n == 800);
            end else if (r < 85) begin
                release_live($urandom_range(live_offsets.size() - 1), $urandom_range(9) == 0);
            end else if (r < 95) begin
                queue_request(ffba_pkg::OP_FREE, $urandom_range(0, 1023),
                              $urandom_range(0, 1023), 1'b0);
            end else begin
                queue_request(ffba_pkg::OP_FREE, $urandom_range(0, 1023), 0, 1'b0);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && n_got == n_sent);
        repeat (400) @(posedge aclk);
        if (n_errors == 0 && expected_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
